// ===== hdl/itgi_pkg.sv =====
// Shared types, codes and defaults for the interval table gap insert block.
package itgi_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefAddrWidth  = 64;

  // Port payload widths: fixed by the field layout.
  localparam int InDataW  = 136;
  localparam int OutDataW = 144;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_EXAM,
    S_TAIL,
    S_DECIDE,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic read_done;
    logic reject_empty;
    logic start_pass;
    logic copy_pass;
    logic fetch;
    logic gap;
    logic step;
    logic tail;
    logic reject_full;
    logic finish;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic range_empty;
    logic table_empty;
    logic gap_before;
    logic last_entry;
    logic overflow;
    logic copy_pass;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/itgi_ctrl.sv =====
// Controller state machine for the interval table gap insert block.
module itgi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  itgi_pkg::dp_stat_t stat,
  output itgi_pkg::dp_cmd_t  cmd
);

  itgi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itgi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == itgi_pkg::S_IDLE);
    unique case (state)
      itgi_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = itgi_pkg::S_CHECK;
        end
      end
      itgi_pkg::S_CHECK: begin
        if (stat.is_read) begin
          cmd.read_done = 1'b1;
          state_next    = itgi_pkg::S_RESULT;
        end else if (stat.range_empty) begin
          cmd.reject_empty = 1'b1;
          state_next       = itgi_pkg::S_RESULT;
        end else begin
          cmd.start_pass = 1'b1;
          state_next     = stat.table_empty ? itgi_pkg::S_TAIL : itgi_pkg::S_FETCH;
        end
      end
      itgi_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = itgi_pkg::S_EXAM;
      end
      itgi_pkg::S_EXAM: begin
        // A gap ahead of the entry goes out first, then the entry itself.
        if (stat.gap_before) begin
          cmd.gap = 1'b1;
        end else begin
          cmd.step   = 1'b1;
          state_next = stat.last_entry ? itgi_pkg::S_TAIL : itgi_pkg::S_FETCH;
        end
      end
      itgi_pkg::S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = stat.copy_pass ? itgi_pkg::S_FINISH : itgi_pkg::S_DECIDE;
      end
      itgi_pkg::S_DECIDE: begin
        if (stat.overflow) begin
          cmd.reject_full = 1'b1;
          state_next      = itgi_pkg::S_RESULT;
        end else begin
          cmd.start_pass = 1'b1;
          cmd.copy_pass  = 1'b1;
          state_next     = stat.table_empty ? itgi_pkg::S_TAIL : itgi_pkg::S_FETCH;
        end
      end
      itgi_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = itgi_pkg::S_RESULT;
      end
      itgi_pkg::S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = itgi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = itgi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/itgi_dp.sv =====
// Datapath of the interval table gap insert block: table memory, walk and output register.
module itgi_dp #(
  parameter int TABLE_DEPTH = itgi_pkg::DefTableDepth,
  parameter int ADDR_WIDTH  = itgi_pkg::DefAddrWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tuser,
  input  logic [itgi_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [itgi_pkg::OutDataW-1:0] m_tdata,
  input  itgi_pkg::dp_cmd_t             cmd,
  output itgi_pkg::dp_stat_t            stat
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(TABLE_DEPTH + 2);
  localparam int SW = ((CW > NW) ? CW : NW) + 1;
  localparam int XW = (CW > 6) ? CW : 6;
  localparam int AW = ADDR_WIDTH;

  // Two banks: walk reads the live bank and rebuilds into the other one.
  logic [2*AW-1:0] mem [2**(IW+1)];
  logic [2*AW-1:0] mem_q;
  logic            mem_re;
  logic            mem_we;
  logic [IW:0]     mem_raddr;
  logic [IW:0]     mem_waddr;
  logic [2*AW-1:0] mem_wdata;

  logic            bank;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd_ptr;
  logic [CW-1:0]   wr_ptr;
  logic [NW-1:0]   n_gaps;
  logic [AW-1:0]   cursor;
  logic [AW-1:0]   lo;
  logic [AW-1:0]   hi;
  logic            is_read;
  logic [5:0]      idx;
  logic            copy;

  logic [1:0]      res_status;
  logic [6:0]      res_pieces;
  logic [AW-1:0]   res_base;
  logic [AW-1:0]   res_limit;

  logic [AW-1:0]   q_base;
  logic [AW-1:0]   q_limit;
  logic            in_walk;
  logic            tail_gap;
  logic            idx_ok;
  logic [AW-1:0]   gap_end;

  assign q_base   = mem_q[AW-1:0];
  assign q_limit  = mem_q[2*AW-1:AW];
  assign in_walk  = (q_limit > lo) && (q_base < hi);
  assign tail_gap = (cursor < hi);
  assign idx_ok   = (XW'(idx) < XW'(count));
  // A gap ends at the next entry, or at the request end when that entry lies past it.
  assign gap_end  = (q_base < hi) ? q_base : hi;

  assign stat.is_read     = is_read;
  assign stat.range_empty = (lo >= hi);
  assign stat.table_empty = (count == '0);
  assign stat.gap_before  = tail_gap && (cursor < q_base);
  assign stat.last_entry  = ((rd_ptr + CW'(1)) == count);
  assign stat.overflow    = (SW'(count) + SW'(n_gaps)) > SW'(TABLE_DEPTH);
  assign stat.copy_pass   = copy;
  assign stat.out_free    = !m_tvalid || m_tready;

  assign mem_re    = cmd.accept || cmd.fetch;
  assign mem_raddr = cmd.accept ? {bank, IW'(s_tdata[133:128])} : {bank, rd_ptr[IW-1:0]};
  assign mem_waddr = {~bank, wr_ptr[IW-1:0]};
  assign mem_we    = copy && (cmd.gap || cmd.step || (cmd.tail && tail_gap));

  always_comb begin
    priority if (cmd.gap) begin
      mem_wdata = {gap_end, cursor};
    end else if (cmd.tail) begin
      mem_wdata = {hi, cursor};
    end else begin
      mem_wdata = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= 1'b0;
      count    <= '0;
      copy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.start_pass) begin
        copy <= cmd.copy_pass;
      end
      if (cmd.finish) begin
        count <= wr_ptr;
        bank  <= ~bank;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Walk registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_read <= (s_tuser == itgi_pkg::CMD_READ);
      lo      <= s_tdata[AW-1:0];
      hi      <= s_tdata[64+AW-1:64];
      idx     <= s_tdata[133:128];
    end
    if (cmd.start_pass) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      n_gaps <= '0;
      cursor <= lo;
    end
    if (cmd.gap) begin
      n_gaps <= n_gaps + NW'(1);
      cursor <= gap_end;
      if (copy) begin
        wr_ptr <= wr_ptr + CW'(1);
      end
    end
    if (cmd.step) begin
      rd_ptr <= rd_ptr + CW'(1);
      if (in_walk && (q_limit > cursor)) begin
        cursor <= q_limit;
      end
      if (copy) begin
        wr_ptr <= wr_ptr + CW'(1);
      end
    end
    if (cmd.tail && tail_gap) begin
      n_gaps <= n_gaps + NW'(1);
      if (copy) begin
        wr_ptr <= wr_ptr + CW'(1);
      end
    end
    if (cmd.read_done) begin
      res_pieces <= '0;
      if (idx_ok) begin
        res_status <= itgi_pkg::ST_OK;
        res_base   <= q_base;
        res_limit  <= q_limit;
      end else begin
        res_status <= itgi_pkg::ST_BAD_INDEX;
        res_base   <= '0;
        res_limit  <= '0;
      end
    end
    if (cmd.reject_empty || cmd.reject_full || cmd.finish) begin
      res_base  <= '0;
      res_limit <= '0;
    end
    if (cmd.reject_empty) begin
      res_status <= itgi_pkg::ST_EMPTY;
      res_pieces <= '0;
    end
    if (cmd.reject_full) begin
      res_status <= itgi_pkg::ST_FULL;
      res_pieces <= '0;
    end
    if (cmd.finish) begin
      res_status <= itgi_pkg::ST_OK;
      res_pieces <= 7'(n_gaps);
    end
    if (cmd.emit) begin
      m_tdata <= {64'(res_limit), 64'(res_base), 7'(count), res_pieces, res_status};
    end
  end

endmodule

// ===== hdl/interval_table_gap_insert_core.sv =====
// Top level of the interval table gap insert block.
//
// Channel  Dir  Beat contents
// s_*      in   tuser: command; tdata: range_start, range_stop, entry_index, zero pad
// m_*      out  tdata: status, pieces_added, entries_used, entry_base, entry_limit
//
// A read goes from accept through a check state to the result; so does an add with an
// empty range. Any other add walks the table in a count pass and then, unless the gaps
// found would overflow the table, in a rebuild pass into the other bank.
// Reset clears the entry count, bank select, pass mode and output valid only; no clearing pass runs.
// A result waiting in the output register does not block the next accept.
module interval_table_gap_insert_core #(
  parameter int TABLE_DEPTH = itgi_pkg::DefTableDepth,
  parameter int ADDR_WIDTH  = itgi_pkg::DefAddrWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tuser: command
  input  logic                          s_tuser,
  // tdata: range_start[63:0], range_stop[127:64], entry_index[133:128], pad
  input  logic [itgi_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: status[1:0], pieces_added[8:2], entries_used[15:9],
  //        entry_base[79:16], entry_limit[143:80]
  output logic [itgi_pkg::OutDataW-1:0] m_tdata
);

  itgi_pkg::dp_cmd_t  cmd;
  itgi_pkg::dp_stat_t stat;

  // Sequence each request.
  itgi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table, walk it and drive the result beat.
  itgi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
